// ----- src/salfu_pkg.sv -----
// shared types and codes for the lfu set-associative cache
package salfu_pkg;

    typedef enum logic [1:0] {
        MODE_PRELOAD = 2'd0,
        MODE_READ    = 2'd1,
        MODE_WRITE   = 2'd2,
        MODE_NONE    = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        REG_SET_BITS    = 2'd0,
        REG_OFFSET_BITS = 2'd1,
        REG_WAYS_IN_USE = 2'd2
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRAP,
        ST_LOOK,
        ST_CHECK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic capture;
        logic wrap_step;
        logic update;
    } dp_cmd_t;

    typedef struct packed {
        logic wrap_needed;
    } dp_status_t;

    localparam int TAG_W   = 12;
    localparam int COUNT_W = 8;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

endpackage

// ----- src/salfu_ram.sv -----
// generic single-port ram with registered read
module salfu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                       wdata,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;
endmodule

// ----- src/salfu_ctrl.sv -----
// controller state machine sequencing one item at a time
module salfu_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  salfu_pkg::dp_status_t status,
    output salfu_pkg::dp_cmd_t   cmd,
    output logic                 busy,
    output logic                 done
);
    import salfu_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        done       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_WRAP;
                end
            end
            ST_WRAP:
            begin
                // fold the address into the backing memory range
                if (status.wrap_needed)
                begin
                    cmd.wrap_step = 1'b1;
                end
                else
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                cmd.update = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                done       = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule

// ----- src/salfu_dp.sv -----
// datapath: config, address split, tag/count rams, backing memory, result
module salfu_dp #(
    parameter int SETS        = 16,
    parameter int WAYS        = 4,
    parameter int BLOCK_BYTES = 16,
    parameter int MEM_BYTES   = 4096
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  salfu_pkg::dp_cmd_t    cmd,
    output salfu_pkg::dp_status_t status,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [2:0]            cfg_data,
    input  logic [1:0]            mode,
    input  logic [11:0]           address,
    input  logic [7:0]            write_data,
    output logic [7:0]            read_data,
    output logic                  hit,
    output logic [1:0]            way,
    output logic [3:0]            set_index
);
    import salfu_pkg::*;

    localparam int SW     = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WW     = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int NW_W   = $clog2(WAYS + 1);
    localparam int MA_W   = $clog2(MEM_BYTES);
    localparam int SB_MAX = $clog2(SETS + 1) - 1;
    localparam int OB_MAX = $clog2(BLOCK_BYTES + 1) - 1;
    localparam int LINE_W = TAG_W + COUNT_W;

    logic [2:0] set_bits_reg, offset_bits_reg, ways_in_use_reg;

    logic [1:0]        mode_reg;
    logic [11:0]       maddr_reg;
    logic [7:0]        wdata_reg;
    logic [SW-1:0]     set_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic [NW_W-1:0]   nways_reg;
    logic [SW-1:0]     set_next;
    logic [TAG_W-1:0]  tag_next;
    logic [NW_W-1:0]   nways_next;

    logic [WAYS-1:0]   valid_reg [SETS];

    logic [7:0]  read_data_reg;
    logic        hit_reg;
    logic [1:0]  way_reg;
    logic [3:0]  set_index_reg;

    logic              mem_we;
    logic [7:0]        mem_rd;
    logic [LINE_W-1:0] way_rd [WAYS];
    logic [COUNT_W-1:0] way_cnt [WAYS];
    logic [WAYS-1:0]   way_we;
    logic [LINE_W-1:0] line_wdata;

    logic              hit_c;
    logic [WW-1:0]     hit_way;
    logic [WW-1:0]     victim;
    logic [COUNT_W-1:0] min_cnt;
    logic [WW-1:0]     target;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg    <= 3'd4;
            offset_bits_reg <= 3'd4;
            ways_in_use_reg <= 3'd4;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SET_BITS:    set_bits_reg    <= cfg_data;
                REG_OFFSET_BITS: offset_bits_reg <= cfg_data;
                REG_WAYS_IN_USE: ways_in_use_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // address split with the clamped field widths
    always_comb
    begin
        int sb;
        int ob;
        int nw;
        logic [11:0] shifted;
        sb = (int'(set_bits_reg) > SB_MAX) ? SB_MAX : int'(set_bits_reg);
        ob = (int'(offset_bits_reg) > OB_MAX) ? OB_MAX : int'(offset_bits_reg);
        nw = int'(ways_in_use_reg);
        if (nw < 1)
        begin
            nw = 1;
        end
        if (nw > WAYS)
        begin
            nw = WAYS;
        end
        shifted    = address >> ob;
        set_next   = SW'(shifted & 12'((32'd1 << sb) - 32'd1));
        tag_next   = address >> (sb + ob);
        nways_next = NW_W'(nw);
    end

    assign status.wrap_needed = (32'(maddr_reg) >= 32'(MEM_BYTES));

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg  <= mode;
            maddr_reg <= address;
            wdata_reg <= write_data;
            set_reg   <= set_next;
            tag_reg   <= tag_next;
            nways_reg <= nways_next;
        end
        else if (cmd.wrap_step)
        begin
            maddr_reg <= maddr_reg - 12'(MEM_BYTES);
        end
    end

    // a line never filled counts as zero uses
    always_comb
    begin
        for (int i = 0; i < WAYS; i++)
        begin
            way_cnt[i] = valid_reg[set_reg][i] ? way_rd[i][COUNT_W-1:0] : '0;
        end
    end

    // hit search and least-used victim over the ways in use
    always_comb
    begin
        hit_c   = 1'b0;
        hit_way = '0;
        victim  = '0;
        min_cnt = way_cnt[0];
        for (int i = 0; i < WAYS; i++)
        begin
            if (i < int'(nways_reg))
            begin
                if (!hit_c && valid_reg[set_reg][i]
                    && way_rd[i][LINE_W-1:COUNT_W] == tag_reg)
                begin
                    hit_c   = 1'b1;
                    hit_way = WW'(i);
                end
                if (i > 0 && way_cnt[i] < min_cnt)
                begin
                    min_cnt = way_cnt[i];
                    victim  = WW'(i);
                end
            end
        end
    end

    always_comb
    begin
        logic [COUNT_W-1:0] cnt;
        target = hit_c ? hit_way : victim;
        cnt    = way_rd[target][COUNT_W-1:0];
        if (hit_c)
        begin
            line_wdata = {way_rd[target][LINE_W-1:COUNT_W],
                          (cnt == COUNT_MAX) ? cnt : cnt + 8'd1};
        end
        else
        begin
            line_wdata = {tag_reg, 8'd1};
        end
        way_we = '0;
        mem_we = 1'b0;
        if (cmd.update)
        begin
            case (mode_reg)
                MODE_PRELOAD: mem_we = 1'b1;
                MODE_READ:    way_we[target] = 1'b1;
                MODE_WRITE:
                begin
                    mem_we = 1'b1;
                    if (hit_c)
                    begin
                        way_we[target] = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < SETS; s++)
            begin
                valid_reg[s] <= '0;
            end
        end
        else if (cmd.update && mode_reg == MODE_READ)
        begin
            valid_reg[set_reg][target] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            read_data_reg <= '0;
            hit_reg       <= 1'b0;
            way_reg       <= '0;
            set_index_reg <= 4'(set_reg);
            case (mode_reg)
                MODE_PRELOAD: read_data_reg <= wdata_reg;
                MODE_READ:
                begin
                    read_data_reg <= mem_rd;
                    hit_reg       <= hit_c;
                    way_reg       <= 2'(target);
                end
                MODE_WRITE:
                begin
                    read_data_reg <= wdata_reg;
                    hit_reg       <= hit_c;
                    way_reg       <= hit_c ? 2'(hit_way) : 2'd0;
                end
                default: set_index_reg <= '0;
            endcase
        end
    end

    assign read_data = read_data_reg;
    assign hit       = hit_reg;
    assign way       = way_reg;
    assign set_index = set_index_reg;

    salfu_ram #(
        .WIDTH (8),
        .DEPTH (MEM_BYTES)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .addr  (MA_W'(maddr_reg)),
        .wdata (wdata_reg),
        .rdata (mem_rd)
    );

    // one tag and count ram per way, indexed by set
    for (genvar g = 0; g < WAYS; g++)
    begin : g_way
        salfu_ram #(
            .WIDTH (LINE_W),
            .DEPTH (SETS)
        ) u_line (
            .clk   (clk),
            .we    (way_we[g]),
            .addr  (set_reg),
            .wdata (line_wdata),
            .rdata (way_rd[g])
        );
    end
endmodule

// ----- src/set_assoc_cache_lfu.sv -----
// top level of the lfu set-associative cache
// One item is taken when start is high while busy is low; its result appears on
// read_data, hit, way and set_index for exactly one cycle with done high, and must be
// captured then. An item passes through capture, a wrap state that folds an address
// beyond the backing memory size back into range (never needed when MEM_BYTES >= 4096),
// a lookup state for the registered reads of the tag/count rams and backing memory,
// an update state, and the result state. Only reads allocate lines; a read miss
// replaces the lowest-numbered least-used way. Lines hold tags and use counts only,
// since every byte delivered comes from the backing memory. Configuration writes
// take effect at once and are meant for when busy is low.
module set_assoc_cache_lfu #(
    parameter int SETS        = 16,
    parameter int WAYS        = 4,
    parameter int BLOCK_BYTES = 16,
    parameter int MEM_BYTES   = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    output logic        done,
    input  logic [1:0]  mode,
    input  logic [11:0] address,
    input  logic [7:0]  write_data,
    output logic [7:0]  read_data,
    output logic        hit,
    output logic [1:0]  way,
    output logic [3:0]  set_index,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [2:0]  cfg_data
);
    import salfu_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    salfu_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    salfu_dp #(
        .SETS        (SETS),
        .WAYS        (WAYS),
        .BLOCK_BYTES (BLOCK_BYTES),
        .MEM_BYTES   (MEM_BYTES)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mode       (mode),
        .address    (address),
        .write_data (write_data),
        .read_data  (read_data),
        .hit        (hit),
        .way        (way),
        .set_index  (set_index)
    );
endmodule

// ----- sim/tb_set_assoc_cache_lfu.sv -----
// testbench for the lfu set-associative cache: queued items, predicted results, scoreboard
`timescale 1ns / 100ps

module tb_set_assoc_cache_lfu;
    import salfu_pkg::*;

    localparam int NSETS = 16;
    localparam int NWAYS = 4;
    localparam int NBYTES = 16;
    localparam int MEMSZ = 4096;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [1:0]  mode;
        logic [11:0] address;
        logic [7:0]  wdata;
    } access_t;

    typedef struct packed {
        logic [7:0] rdata;
        logic       hit;
        logic [1:0] way;
        logic [3:0] set;
    } lookup_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy, done;
    logic [1:0]  mode = '0;
    logic [11:0] address = '0;
    logic [7:0]  write_data = '0;
    logic [7:0]  read_data;
    logic        hit;
    logic [1:0]  way;
    logic [3:0]  set_index;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [2:0]  cfg_data = '0;

    set_assoc_cache_lfu dut (.*);

    always #2 clk = ~clk;

    // predictor state
    logic [7:0]  mem_img [MEMSZ];
    logic        ln_valid [NSETS][NWAYS];
    logic [7:0]  ln_count [NSETS][NWAYS];
    logic [11:0] ln_tag [NSETS][NWAYS];
    logic [2:0]  cur_set_bits, cur_off_bits, cur_ways;

    access_t pending_items[$];
    lookup_t expected_lookups[$];
    int errors = 0;
    int mismatches = 0;
    int cycles = 0;
    int accepted = 0;
    int n_hits = 0;
    int n_results = 0;

    function automatic int clamp_width(int req, int limit);
        int k;
        k = 0;
        while (k < req && (1 << (k + 1)) <= limit) k++;
        return k;
    endfunction

    function automatic lookup_t predict_lookup(access_t it);
        lookup_t r;
        int sb, ob, nw, st, tg, w, i;
        bit h;
        logic [7:0] minc;
        sb = clamp_width(int'(cur_set_bits), NSETS);
        ob = clamp_width(int'(cur_off_bits), NBYTES);
        nw = int'(cur_ways);
        if (nw < 1) nw = 1;
        if (nw > NWAYS) nw = NWAYS;
        st = int'(it.address >> ob) & ((1 << sb) - 1);
        tg = int'(it.address >> (sb + ob));
        r = '0;
        if (it.mode == MODE_NONE) return r;
        r.set = 4'(st);
        if (it.mode == MODE_PRELOAD) begin
            mem_img[it.address] = it.wdata;
            r.rdata = it.wdata;
            return r;
        end
        h = 0;
        w = 0;
        for (i = 0; i < nw; i++)
            if (!h && ln_valid[st][i] && ln_tag[st][i] == 12'(tg)) begin
                h = 1;
                w = i;
            end
        if (it.mode == MODE_WRITE) begin
            mem_img[it.address] = it.wdata;
            r.rdata = it.wdata;
            if (h) begin
                if (ln_count[st][w] < COUNT_MAX) ln_count[st][w]++;
            end else w = 0;
        end else begin
            r.rdata = mem_img[it.address];
            if (h) begin
                if (ln_count[st][w] < COUNT_MAX) ln_count[st][w]++;
            end else begin
                minc = ln_count[st][0];
                w = 0;
                for (i = 1; i < nw; i++)
                    if (ln_count[st][i] < minc) begin
                        minc = ln_count[st][i];
                        w = i;
                    end
                ln_valid[st][w] = 1'b1;
                ln_count[st][w] = 8'd1;
                ln_tag[st][w] = 12'(tg);
            end
        end
        r.hit = h;
        r.way = 2'(w);
        return r;
    endfunction

    // driver
    int gap = 0;
    always @(posedge clk) begin
        if (rst_n) begin
            if (start && !busy) begin
                start <= 1'b0;
                gap = int'($urandom_range(0, 9));
            end else if (!start && pending_items.size() > 0) begin
                if (gap > 0) gap--;
                else begin
                    access_t it;
                    it = pending_items.pop_front();
                    mode <= it.mode;
                    address <= it.address;
                    write_data <= it.wdata;
                    expected_lookups.push_back(predict_lookup(it));
                    accepted++;
                    start <= 1'b1;
                end
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        cycles++;
        if (rst_n && done) begin
            lookup_t exp_r;
            n_results++;
            if (expected_lookups.size() == 0) begin
                errors++;
                if (mismatches++ < 10) $display("unexpected result at cycle %0d", cycles);
            end else begin
                exp_r = expected_lookups.pop_front();
                if (hit) n_hits++;
                if (read_data !== exp_r.rdata || hit !== exp_r.hit || way !== exp_r.way
                        || set_index !== exp_r.set) begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("mismatch: exp data %h hit %b way %0d set %0d, got %h %b %0d %0d",
                            exp_r.rdata, exp_r.hit, exp_r.way, exp_r.set,
                            read_data, hit, way, set_index);
                end
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic add_item(logic [1:0] m, logic [11:0] a, logic [7:0] d);
        access_t it;
        it.mode = m;
        it.address = a;
        it.wdata = d;
        pending_items.push_back(it);
    endtask

    // read only bytes already stored, tracked at queue time
    bit queued_known [MEMSZ];
    logic [11:0] known_addrs[$];

    task automatic queue_store(logic [1:0] m, logic [11:0] a, logic [7:0] d);
        if (!queued_known[a]) begin
            queued_known[a] = 1;
            known_addrs.push_back(a);
        end
        add_item(m, a, d);
    endtask

    task automatic drain;
        wait (pending_items.size() == 0 && expected_lookups.size() == 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [2:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_SET_BITS: cur_set_bits = val;
            REG_OFFSET_BITS: cur_off_bits = val;
            default: cur_ways = val;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase(int n);
        int i, r;
        logic [11:0] a;
        for (i = 0; i < n; i++) begin
            r = int'($urandom_range(0, 99));
            if (r < 25 || known_addrs.size() == 0)
                queue_store(MODE_PRELOAD, 12'($urandom_range(0, 4095)),
                    8'($urandom_range(0, 255)));
            else if (r < 70) begin
                // reads concentrated on known bytes so lines are reused
                a = known_addrs[$urandom_range(0, known_addrs.size() - 1)];
                add_item(MODE_READ, a, 8'($urandom_range(0, 255)));
            end else if (r < 90) begin
                if (r < 80) a = known_addrs[$urandom_range(0, known_addrs.size() - 1)];
                else a = 12'($urandom_range(0, 4095));
                queue_store(MODE_WRITE, a, 8'($urandom_range(0, 255)));
            end else
                add_item(MODE_NONE, 12'($urandom_range(0, 4095)), 8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        int i, p;
        logic [2:0] sb_set[5] = '{3'd4, 3'd0, 3'd7, 3'd2, 3'd4};
        logic [2:0] ob_set[5] = '{3'd4, 3'd7, 3'd0, 3'd1, 3'd3};
        logic [2:0] wy_set[5] = '{3'd4, 3'd1, 3'd0, 3'd7, 3'd2};
        for (i = 0; i < MEMSZ; i++) begin
            mem_img[i] = '0;
            queued_known[i] = 0;
        end
        for (i = 0; i < NSETS * NWAYS; i++) begin
            ln_valid[i / NWAYS][i % NWAYS] = 1'b0;
            ln_count[i / NWAYS][i % NWAYS] = '0;
            ln_tag[i / NWAYS][i % NWAYS] = '0;
        end
        cur_set_bits = 3'd4;
        cur_off_bits = 3'd4;
        cur_ways = 3'd4;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: extremes, every mode, lfu fill order, write hit, unused mode
        queue_store(MODE_PRELOAD, 12'h000, 8'h00);
        queue_store(MODE_PRELOAD, 12'hfff, 8'hff);
        queue_store(MODE_PRELOAD, 12'h010, 8'h5a);
        add_item(MODE_READ, 12'h000, 8'h00);
        add_item(MODE_READ, 12'h000, 8'hff);
        add_item(MODE_READ, 12'hfff, 8'h00);
        queue_store(MODE_WRITE, 12'h000, 8'ha5);
        add_item(MODE_READ, 12'h000, 8'h00);
        queue_store(MODE_WRITE, 12'h7f0, 8'h3c);
        for (i = 0; i < 5; i++) begin
            queue_store(MODE_PRELOAD, 12'(32'h100 * i + 32'h020), 8'(16 + i));
            add_item(MODE_READ, 12'(32'h100 * i + 32'h020), 8'h00);
        end
        add_item(MODE_READ, 12'h120, 8'h00);
        add_item(MODE_NONE, 12'hfff, 8'hff);
        add_item(MODE_NONE, 12'h000, 8'h00);
        drain();

        // saturate one line's count
        for (i = 0; i < 270; i++) add_item(MODE_READ, 12'h010, 8'h00);
        drain();

        for (p = 0; p < 5; p++) begin
            write_reg(REG_SET_BITS, sb_set[p]);
            write_reg(REG_OFFSET_BITS, ob_set[p]);
            write_reg(REG_WAYS_IN_USE, wy_set[p]);
            random_phase(70);
            drain();
        end

        $display("covered %0d items, %0d results, %0d hits, over five register settings",
            accepted, n_results, n_hits);
        if (errors == 0 && expected_lookups.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
